FILE: hw/rtl/pcbp_pkg.sv
// pcbp_pkg: shared constants and types of the prefix code bit packer.
// Used by every file of the block except pcbp_ram; depends on nothing.

package pcbp_pkg;

   localparam int TABLE_DEPTH   = 256;
   localparam int MAX_CODE_BITS = 32;

   localparam int OP_W    = 2;
   localparam int SYM_W   = 8;
   localparam int CODE_W  = 32;
   localparam int LEN_W   = 6;
   localparam int BYTE_W  = 8;
   localparam int FILL_W  = 3;

   localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int LEN_CAP = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
   localparam int ENTRY_W = CODE_W + LEN_W;
   localparam int WORD_W  = BYTE_W + CODE_W;
   localparam int SHAMT_W = $clog2(WORD_W + 1);
   localparam int CNT_W   = SHAMT_W - FILL_W;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   typedef struct packed {
      logic              hit;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } lookup_type;

   typedef struct packed {
      logic              load;
      logic [CNT_W-1:0]  count;
      logic [CODE_W-1:0] bytes;
   } burst_type;

endpackage

FILE: hw/rtl/pcbp_ifs.sv
// pcbp_req_if, pcbp_rsp_if: valid/ready channels of the packer.
// Depends on pcbp_pkg for payload widths.

interface pcbp_req_if;
   logic                           valid;
   logic                           ready;
   logic [pcbp_pkg::OP_W-1:0]      operation;
   logic [pcbp_pkg::SYM_W-1:0]     symbol_value;
   logic [pcbp_pkg::CODE_W-1:0]    code_pattern;
   logic [pcbp_pkg::LEN_W-1:0]     code_length;

   modport source (output valid, output operation, output symbol_value,
                   output code_pattern, output code_length, input ready);
   modport sink   (input valid, input operation, input symbol_value,
                   input code_pattern, input code_length, output ready);
endinterface

interface pcbp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pcbp_pkg::BYTE_W-1:0]    packed_byte;
   logic                           last_of_run;

   modport source (output valid, output packed_byte, output last_of_run, input ready);
   modport sink   (input valid, input packed_byte, input last_of_run, output ready);
endinterface

FILE: hw/rtl/pcbp_ram.sv
// pcbp_ram: generic single-port RAM, one access per cycle, registered read.
// No dependencies.

module pcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                       wr_data,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/pcbp_table.sv
// pcbp_table: code/length table in one RAM plus per-entry valid bits.
// Depends on pcbp_pkg and pcbp_ram. Lookup data is registered and appears in the cycle after rd_en.

module pcbp_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic                          rd_en,
   input  logic [pcbp_pkg::SYM_W-1:0]    sym,
   input  logic [pcbp_pkg::CODE_W-1:0]   wr_code,
   input  logic [pcbp_pkg::LEN_W-1:0]    wr_len,
   output pcbp_pkg::lookup_type          lookup
);

   logic                                 in_range;
   logic [pcbp_pkg::IDX_W-1:0]           idx;
   logic                                 wr_hit;
   logic [pcbp_pkg::LEN_W-1:0]           len_sat;
   logic [pcbp_pkg::ENTRY_W-1:0]         rd_entry;
   logic [pcbp_pkg::TABLE_DEPTH-1:0]     valid_ff;
   logic [pcbp_pkg::TABLE_DEPTH-1:0]     valid_in;
   logic                                 hit_ff;
   logic                                 hit_in;

   assign in_range = {1'b0, sym} < (pcbp_pkg::SYM_W + 1)'(pcbp_pkg::TABLE_DEPTH);
   assign idx      = sym[pcbp_pkg::IDX_W-1:0];
   assign wr_hit   = wr_en && in_range;
   assign len_sat  = (wr_len > pcbp_pkg::LEN_W'(pcbp_pkg::LEN_CAP)) ?
                     pcbp_pkg::LEN_W'(pcbp_pkg::LEN_CAP) : wr_len;

   pcbp_ram #(
      .WIDTH (pcbp_pkg::ENTRY_W),
      .DEPTH (pcbp_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_hit),
      .rd_en   (rd_en),
      .addr    (idx),
      .wr_data ({wr_code, len_sat}),
      .rd_data (rd_entry)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr_hit) begin
         valid_in[idx] = 1'b1;
      end
      hit_in = hit_ff;
      if (rd_en) begin
         hit_in = in_range && valid_ff[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

   assign lookup.hit  = hit_ff;
   assign lookup.code = rd_entry[pcbp_pkg::ENTRY_W-1:pcbp_pkg::LEN_W];
   assign lookup.len  = rd_entry[pcbp_pkg::LEN_W-1:0];

endmodule

FILE: hw/rtl/pcbp_merge.sv
// pcbp_merge: lookup stage; merges the code into the bit accumulator,
// keeps the partial byte and hands full bytes to pcbp_emit. Depends on pcbp_pkg.

module pcbp_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [pcbp_pkg::OP_W-1:0]     op,
   input  pcbp_pkg::lookup_type          lookup,
   input  logic                          emit_free,
   output logic                          ready,
   output pcbp_pkg::burst_type           burst
);

   logic                                 s1_valid_ff, s1_valid_in;
   logic [pcbp_pkg::OP_W-1:0]            s1_op_ff, s1_op_in;
   logic [pcbp_pkg::BYTE_W-1:0]          acc_ff, acc_in;
   logic [pcbp_pkg::FILL_W-1:0]          fill_ff, fill_in;

   logic [pcbp_pkg::LEN_W-1:0]           len;
   logic [pcbp_pkg::CODE_W-1:0]          code;
   logic [pcbp_pkg::SHAMT_W-1:0]         shamt;
   logic [pcbp_pkg::SHAMT_W-1:0]         total;
   logic [pcbp_pkg::CNT_W-1:0]           nbytes;
   logic [pcbp_pkg::WORD_W-1:0]          word;
   logic [pcbp_pkg::WORD_W-1:0]          rest;
   logic [pcbp_pkg::CNT_W-1:0]           out_count;
   logic [pcbp_pkg::CODE_W-1:0]          out_bytes;
   logic [pcbp_pkg::BYTE_W-1:0]          new_acc;
   logic [pcbp_pkg::FILL_W-1:0]          new_fill;
   logic                                 produce;
   logic                                 advance;

   always_comb begin
      len    = lookup.hit ? lookup.len : '0;
      code   = lookup.code & ~({pcbp_pkg::CODE_W{1'b1}} << len);
      shamt  = pcbp_pkg::SHAMT_W'(pcbp_pkg::WORD_W) - pcbp_pkg::SHAMT_W'(fill_ff)
               - pcbp_pkg::SHAMT_W'(len);
      total  = pcbp_pkg::SHAMT_W'(fill_ff) + pcbp_pkg::SHAMT_W'(len);
      nbytes = total[pcbp_pkg::SHAMT_W-1:pcbp_pkg::FILL_W];
      word   = {acc_ff, pcbp_pkg::CODE_W'(0)}
               | ({pcbp_pkg::BYTE_W'(0), code} << shamt);
      rest   = word << pcbp_pkg::SHAMT_W'({nbytes, 3'b000});

      out_count = '0;
      out_bytes = word[pcbp_pkg::WORD_W-1 -: pcbp_pkg::CODE_W];
      new_acc   = acc_ff;
      new_fill  = fill_ff;
      case (s1_op_ff)
         pcbp_pkg::OP_ENCODE: begin
            out_count = nbytes;
            new_acc   = rest[pcbp_pkg::WORD_W-1 -: pcbp_pkg::BYTE_W];
            new_fill  = total[pcbp_pkg::FILL_W-1:0];
         end
         pcbp_pkg::OP_FLUSH: begin
            out_count = (fill_ff != '0) ? pcbp_pkg::CNT_W'(1) : '0;
            out_bytes = {acc_ff, (pcbp_pkg::CODE_W - pcbp_pkg::BYTE_W)'(0)};
            new_acc   = '0;
            new_fill  = '0;
         end
         default: begin
         end
      endcase

      produce = out_count != '0;
      advance = s1_valid_ff && (!produce || emit_free);
      ready   = !s1_valid_ff || advance;

      s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_op_in    = accept ? op : s1_op_ff;
      acc_in      = advance ? new_acc : acc_ff;
      fill_in     = advance ? new_fill : fill_ff;

      burst.load  = advance && produce;
      burst.count = out_count;
      burst.bytes = out_bytes;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_op_ff    <= pcbp_pkg::OP_LOAD;
         acc_ff      <= '0;
         fill_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_op_ff    <= s1_op_in;
         acc_ff      <= acc_in;
         fill_ff     <= fill_in;
      end
   end

endmodule

FILE: hw/rtl/pcbp_emit.sv
// pcbp_emit: output register; sends the full bytes of one transaction,
// one per cycle unless stalled, marking the last. Depends on pcbp_pkg.

module pcbp_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  pcbp_pkg::burst_type           burst,
   input  logic                          rsp_ready,
   output logic                          free,
   output logic                          rsp_valid,
   output logic [pcbp_pkg::BYTE_W-1:0]   rsp_byte,
   output logic                          rsp_last
);

   logic [pcbp_pkg::CODE_W-1:0]          word_ff, word_in;
   logic [pcbp_pkg::CNT_W-1:0]           cnt_ff, cnt_in;
   logic                                 take;

   assign rsp_valid = cnt_ff != '0;
   assign rsp_byte  = word_ff[pcbp_pkg::CODE_W-1 -: pcbp_pkg::BYTE_W];
   assign rsp_last  = cnt_ff == pcbp_pkg::CNT_W'(1);
   assign take      = rsp_valid && rsp_ready;
   assign free      = !rsp_valid || (rsp_last && rsp_ready);

   always_comb begin
      word_in = word_ff;
      cnt_in  = cnt_ff;
      if (burst.load) begin
         word_in = burst.bytes;
         cnt_in  = burst.count;
      end else if (take) begin
         word_in = word_ff << pcbp_pkg::BYTE_W;
         cnt_in  = cnt_ff - pcbp_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      word_ff <= word_in;
   end

endmodule

FILE: hw/rtl/prefix_code_bit_packer.sv
// prefix_code_bit_packer: table lookup, bit merge and byte output of the packer.
// Depends on pcbp_pkg, pcbp_ifs, pcbp_table, pcbp_merge, pcbp_emit.
// Path: an accepted request is registered in the table read register and the
// merge stage, then its bytes are loaded into the emit output register.
// Throughput: one transaction per cycle while pcbp_emit is free; one yielding
// k bytes (k up to 4) sends one byte per cycle while rsp_ready is high.
// Reset is synchronous: clears table valid bits (lengths read as zero),
// the accumulator and the pipeline; no clearing pass is needed.

module prefix_code_bit_packer (
   input  logic          clock,
   input  logic          reset,
   pcbp_req_if.sink      req_if,
   pcbp_rsp_if.source    rsp_if
);

   logic                 accept;
   logic                 merge_ready;
   logic                 emit_free;
   pcbp_pkg::lookup_type lookup;
   pcbp_pkg::burst_type  burst;

   assign req_if.ready = merge_ready;
   assign accept       = req_if.valid && merge_ready;

   pcbp_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && (req_if.operation == pcbp_pkg::OP_LOAD)),
      .rd_en   (accept && (req_if.operation == pcbp_pkg::OP_ENCODE)),
      .sym     (req_if.symbol_value),
      .wr_code (req_if.code_pattern),
      .wr_len  (req_if.code_length),
      .lookup  (lookup)
   );

   pcbp_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op        (req_if.operation),
      .lookup    (lookup),
      .emit_free (emit_free),
      .ready     (merge_ready),
      .burst     (burst)
   );

   pcbp_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .burst     (burst),
      .rsp_ready (rsp_if.ready),
      .free      (emit_free),
      .rsp_valid (rsp_if.valid),
      .rsp_byte  (rsp_if.packed_byte),
      .rsp_last  (rsp_if.last_of_run)
   );

endmodule

FILE: hw/rtl/pcbp_checker.sv
// pcbp_checker: port-level checks of the packer output channel.
// Depends on pcbp_pkg; bound to prefix_code_bit_packer below.

module pcbp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [pcbp_pkg::BYTE_W-1:0]  rsp_packed_byte,
   input logic                         rsp_last_of_run
);

   // stalled output holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped under stall");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_valid && !rsp_ready |=>
         $stable(rsp_packed_byte) && $stable(rsp_last_of_run))
      else $error("rsp payload changed under stall");

   // bytes of one transaction come without gaps
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
      else $error("run ended without last_of_run");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind prefix_code_bit_packer pcbp_checker u_pcbp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_packed_byte (rsp_if.packed_byte),
   .rsp_last_of_run (rsp_if.last_of_run)
);
